// ===== src/wkrf_pkg.sv =====
`timescale 1ns / 1ps
package wkrf_pkg;

  localparam int unsigned MapIdxW  = 16;
  localparam int unsigned MapDepth = 1 << MapIdxW;
  localparam int unsigned WordW    = 32;
  localparam int unsigned WordIdxW = MapIdxW - 5;
  localparam int unsigned WordsNum = MapDepth / WordW;
  localparam int unsigned CfgW     = 21;
  localparam int unsigned PosW     = 31;

  typedef enum logic [1:0] {
    CFG_WINDOW_SIZE   = 2'd0,
    CFG_WINDOW_STEP   = 2'd1,
    CFG_TRIM_FRACTION = 2'd2
  } cfg_idx_e;

  typedef enum logic {
    OP_MARK  = 1'b0,
    OP_CHECK = 1'b1
  } op_e;

  typedef struct packed {
    logic              operation;
    logic              strand;
    logic [15:0]       window_index;
    logic [PosW-1:0]   read_start;
    logic [PosW-1:0]   read_end;
    logic [PosW-1:0]   read_id;
  } in_item_t;

  typedef struct packed {
    logic [PosW-1:0] kept_id;
    logic            kept_strand;
  } out_item_t;

  // request handed from front to back: window range to scan, or the window to mark
  typedef struct packed {
    logic              operation;
    logic              strand;
    logic [MapIdxW-1:0] idx_lo;
    logic [MapIdxW-1:0] idx_hi;
    logic [PosW-1:0]   read_id;
  } req_t;

  typedef enum logic [3:0] {
    F_IDLE, F_TRIM, F_ADJ, F_DIV1, F_DIV2, F_CLAMP, F_PUSH
  } front_state_e;

  typedef enum logic [2:0] {
    B_CLEAR, B_IDLE, B_READ, B_TEST, B_OUT
  } back_state_e;

endpackage

// ===== src/wkrf_div.sv =====
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle. 34-bit unsigned dividend.
module wkrf_div import wkrf_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [33:0]       dividend_i,
  input  logic [CfgW-1:0]   divisor_i,
  output logic              done_o,
  output logic [33:0]       quot_o
);

  logic [5:0]      cnt_q, cnt_d;
  logic            busy_q, busy_d;
  logic [33:0]     quot_q, quot_d;
  logic [CfgW-1:0] rem_q, rem_d;
  logic [CfgW-1:0] dsr_q, dsr_d;
  logic [CfgW:0]   shifted;
  logic            done_q, done_d;

  always_comb begin
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    quot_d  = quot_q;
    rem_d   = rem_q;
    dsr_d   = dsr_q;
    done_d  = 1'b0;
    shifted = {rem_q, quot_q[33]};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = 6'd34;
      quot_d = dividend_i;
      rem_d  = '0;
      dsr_d  = divisor_i;
    end else if (busy_q) begin
      quot_d = {quot_q[32:0], 1'b0};
      if (shifted >= {1'b0, dsr_q}) begin
        // difference is below the divisor, so it fits
        rem_d     = CfgW'(shifted - {1'b0, dsr_q});
        quot_d[0] = 1'b1;
      end else begin
        rem_d = shifted[CfgW-1:0];
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    dsr_q  <= dsr_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

// ===== src/wkrf_front.sv =====
`timescale 1ns / 1ps
// Classifies items: marks pass straight on, checks get trimmed and divided
// into a clamped window range, or dropped when they miss the marked range.
module wkrf_front import wkrf_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  in_item_t          in_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [CfgW-1:0]   win_size_i,
  input  logic [CfgW-1:0]   win_step_i,
  input  logic [15:0]       trim_frac_i,
  input  logic [MapIdxW:0]  lo_pos_i,
  input  logic [MapIdxW-1:0] hi_pos_i,
  input  logic [MapIdxW:0]  lo_neg_i,
  input  logic [MapIdxW-1:0] hi_neg_i,
  input  logic              mark_busy_i,
  output req_t              req_o,
  output logic              req_valid_o,
  input  logic              req_ready_i
);

  front_state_e   state_q, state_d;
  in_item_t       item_q;
  logic [CfgW-1:0] step_q;
  logic [CfgW-1:0] win_q;
  logic [15:0]    frac_q;
  logic [47:0]    prod_q, prod_d;
  logic signed [33:0] s_q, s_d, e_q, e_d;
  logic           first_zero_q, first_zero_d;
  logic           e_neg_q, e_neg_d;
  logic           e_big_q, e_big_d;
  logic [33:0]    first_q, first_d;
  logic [33:0]    last_q, last_d;
  logic           div_start;
  logic [33:0]    div_dividend;
  logic           div_done;
  logic [33:0]    div_quot;
  logic           div_phase_q, div_phase_d;
  req_t           req_q, req_d;
  logic           req_valid_q, req_valid_d;

  logic signed [32:0] len;
  logic [31:0]    mag;
  logic [31:0]    trim;
  logic [MapIdxW:0] lo_sel;
  logic [MapIdxW-1:0] hi_sel;
  logic [38:0]    hi_lim;
  logic [33:0]    lo_ext, hi_ext;
  logic [33:0]    ci, cj;
  logic           mark_pend;

  assign lo_sel = item_q.strand ? lo_neg_i : lo_pos_i;
  assign hi_sel = item_q.strand ? hi_neg_i : hi_pos_i;
  assign lo_ext = {17'd0, lo_sel};
  assign hi_ext = {18'd0, hi_sel};

  // a mark still queued or being written leaves lo/hi stale
  assign mark_pend = mark_busy_i || (req_valid_q && req_q.operation == OP_MARK);

  assign len = $signed({2'b00, item_q.read_end}) - $signed({2'b00, item_q.read_start})
             + 33'sd1;
  assign mag = len[32] ? 32'(-len) : 32'(len);
  assign trim = prod_q[47:16];

  wkrf_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (step_q),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  always_comb begin
    hi_lim = 39'(step_q) * 39'(hi_sel) + 39'd1;
  end

  always_comb begin
    state_d      = state_q;
    prod_d       = prod_q;
    s_d          = s_q;
    e_d          = e_q;
    first_zero_d = first_zero_q;
    e_neg_d      = e_neg_q;
    e_big_d      = e_big_q;
    first_d      = first_q;
    last_d       = last_q;
    div_phase_d  = div_phase_q;
    div_start    = 1'b0;
    div_dividend = '0;
    req_d        = req_q;
    req_valid_d  = req_valid_q;
    in_ready_o   = 1'b0;
    ci           = (first_q < lo_ext) ? lo_ext : first_q;
    cj           = (last_q > hi_ext) ? hi_ext : last_q;
    if (req_valid_q && req_ready_i) begin
      req_valid_d = 1'b0;
    end
    case (state_q)
      F_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          state_d = (in_i.operation == OP_MARK) ? F_PUSH : F_TRIM;
        end
      end
      F_TRIM: begin
        prod_d  = 48'(mag) * 48'(frac_q);
        state_d = F_ADJ;
      end
      F_ADJ: begin
        if (len[32]) begin
          s_d = $signed({3'b000, item_q.read_start}) - $signed({2'b00, trim});
          e_d = $signed({3'b000, item_q.read_end}) + $signed({2'b00, trim});
        end else begin
          s_d = $signed({3'b000, item_q.read_start}) + $signed({2'b00, trim});
          e_d = $signed({3'b000, item_q.read_end}) - $signed({2'b00, trim});
        end
        state_d = F_DIV1;
        div_phase_d = 1'b0;
      end
      F_DIV1: begin
        // s - win - 1 + step - 1, then e (or -e-1 for negative) in turn
        if (!mark_pend) begin
          first_zero_d = !(s_q > $signed({13'd0, win_q}));
          e_neg_d      = e_q[33];
          e_big_d      = !($signed({1'b0, e_q}) < $signed({1'b0, hi_lim[33:0]}))
                         && !e_q[33] && (hi_lim[38:34] == 5'd0);
          div_start    = 1'b1;
          div_dividend = 34'(s_q - $signed({13'd0, win_q}) - 34'sd2
                         + $signed({13'd0, step_q}));
          state_d      = F_DIV2;
        end
      end
      F_DIV2: begin
        if (div_done) begin
          if (!div_phase_q) begin
            first_d      = first_zero_q ? '0 : div_quot;
            div_phase_d  = 1'b1;
            div_start    = 1'b1;
            div_dividend = e_neg_q ? 34'(-e_q - 34'sd1) : 34'(e_q);
          end else begin
            if (e_big_q) begin
              last_d = hi_ext;
            end else if (e_neg_q) begin
              last_d = ~div_quot;  // -(q) - 1
            end else begin
              last_d = div_quot;
            end
            state_d = F_CLAMP;
          end
        end
      end
      F_CLAMP: begin
        if (lo_sel[MapIdxW] || $signed(last_q) < $signed(lo_ext)
            || first_q > hi_ext) begin
          state_d = F_IDLE;
        end else if (!req_valid_q || req_ready_i) begin
          req_d.operation = OP_CHECK;
          req_d.strand    = item_q.strand;
          req_d.idx_lo    = ci[MapIdxW-1:0];
          req_d.idx_hi    = ($signed(cj) < $signed(ci)) ? ci[MapIdxW-1:0]
                                                       : cj[MapIdxW-1:0];
          req_d.read_id   = item_q.read_id;
          req_valid_d     = 1'b1;
          state_d         = F_IDLE;
        end
      end
      F_PUSH: begin
        if (!req_valid_q || req_ready_i) begin
          req_d.operation = OP_MARK;
          req_d.strand    = item_q.strand;
          req_d.idx_lo    = item_q.window_index;
          req_d.idx_hi    = item_q.window_index;
          req_d.read_id   = item_q.read_id;
          req_valid_d     = 1'b1;
          state_d         = F_IDLE;
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= F_IDLE;
      req_valid_q <= 1'b0;
      div_phase_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      req_valid_q <= req_valid_d;
      div_phase_q <= div_phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == F_IDLE && in_valid_i) begin
      item_q <= in_i;
      step_q <= (win_step_i == '0) ? CfgW'(1) : win_step_i;
      win_q  <= win_size_i;
      frac_q <= trim_frac_i;
    end
    prod_q       <= prod_d;
    s_q          <= s_d;
    e_q          <= e_d;
    first_zero_q <= first_zero_d;
    e_neg_q      <= e_neg_d;
    e_big_q      <= e_big_d;
    first_q      <= first_d;
    last_q       <= last_d;
    req_q        <= req_d;
  end

  assign req_o       = req_q;
  assign req_valid_o = req_valid_q;

endmodule

// ===== src/wkrf_back.sv =====
`timescale 1ns / 1ps
// Owns both bitmaps (32-bit words) and the marked min/max; scans a range.
// After reset the map memory is zeroed one word per cycle.
module wkrf_back import wkrf_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  req_t               req_i,
  input  logic               req_valid_i,
  output logic               req_ready_o,
  output logic [MapIdxW:0]   lo_pos_o,
  output logic [MapIdxW-1:0] hi_pos_o,
  output logic [MapIdxW:0]   lo_neg_o,
  output logic [MapIdxW-1:0] hi_neg_o,
  output logic               mark_busy_o,
  output out_item_t          out_o,
  output logic               out_valid_o,
  input  logic               out_ready_i
);

  logic [WordW-1:0] mem_q [2*WordsNum];

  back_state_e        state_q, state_d;
  req_t               cur_q, cur_d;
  logic [MapIdxW-1:0] idx_q, idx_d;
  logic [WordIdxW:0]  clr_q, clr_d;
  logic [WordW-1:0]   rd_q;
  logic [WordIdxW:0]  addr;
  logic [WordIdxW:0]  wr_addr;
  logic               mark_wr;
  logic               clr_wr;
  logic [WordW-1:0]   wr_data;
  logic [MapIdxW:0]   lo_pos_q, lo_neg_q;
  logic [MapIdxW-1:0] hi_pos_q, hi_neg_q;
  out_item_t          out_q;
  logic               out_valid_q, out_valid_d;
  logic               hit;

  assign addr    = {cur_q.strand, idx_q[MapIdxW-1:5]};
  assign hit     = rd_q[idx_q[4:0]];
  assign wr_addr = clr_wr ? clr_q : addr;
  assign wr_data = clr_wr ? '0 : (rd_q | (WordW'(1) << idx_q[4:0]));

  assign mark_busy_o = (state_q == B_READ || state_q == B_TEST)
                       && (cur_q.operation == OP_MARK);

  always_comb begin
    state_d     = state_q;
    cur_d       = cur_q;
    idx_d       = idx_q;
    clr_d       = clr_q;
    mark_wr     = 1'b0;
    clr_wr      = 1'b0;
    out_valid_d = out_valid_q;
    req_ready_o = 1'b0;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    case (state_q)
      B_CLEAR: begin
        clr_wr = 1'b1;
        clr_d  = clr_q + 1'b1;
        if (clr_q == '1) state_d = B_IDLE;
      end
      B_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cur_d   = req_i;
          idx_d   = req_i.idx_lo;
          state_d = B_READ;
        end
      end
      B_READ: state_d = B_TEST;
      B_TEST: begin
        if (cur_q.operation == OP_MARK) begin
          mark_wr = 1'b1;
          state_d = B_IDLE;
        end else if (hit) begin
          state_d = B_OUT;
        end else if (idx_q >= cur_q.idx_hi) begin
          state_d = B_IDLE;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = B_READ;
        end
      end
      B_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          state_d     = B_IDLE;
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
      lo_pos_q    <= (MapIdxW+1)'(MapDepth);
      lo_neg_q    <= (MapIdxW+1)'(MapDepth);
      hi_pos_q    <= '0;
      hi_neg_q    <= '0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
      if (mark_wr) begin
        if (cur_q.strand) begin
          if ({1'b0, idx_q} < lo_neg_q) lo_neg_q <= {1'b0, idx_q};
          if (idx_q > hi_neg_q) hi_neg_q <= idx_q;
        end else begin
          if ({1'b0, idx_q} < lo_pos_q) lo_pos_q <= {1'b0, idx_q};
          if (idx_q > hi_pos_q) hi_pos_q <= idx_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_q <= mem_q[addr];
    if (mark_wr || clr_wr) mem_q[wr_addr] <= wr_data;
    cur_q <= cur_d;
    idx_q <= idx_d;
    if (state_q == B_OUT && (!out_valid_q || out_ready_i)) begin
      out_q.kept_id     <= cur_q.read_id;
      out_q.kept_strand <= cur_q.strand;
    end
  end

  assign lo_pos_o    = lo_pos_q;
  assign hi_pos_o    = hi_pos_q;
  assign lo_neg_o    = lo_neg_q;
  assign hi_neg_o    = hi_neg_q;
  assign out_o       = out_q;
  assign out_valid_o = out_valid_q;

  a_lo_le_hi: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !lo_pos_q[MapIdxW] |-> lo_pos_q[MapIdxW-1:0] <= hi_pos_q)
    else $error("positive min above max");
  a_out_from_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == B_OUT))
    else $error("result without hit");
  a_mark_no_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == B_OUT |-> cur_q.operation == OP_CHECK)
    else $error("mark produced result");

endmodule

// ===== src/window_keep_read_filter_unit.sv =====
`timescale 1ns / 1ps
// Window keep read filter. Mark requests set bits in per-strand window maps;
// check requests trim the read, derive first/last window with two serial
// divisions by window_step, and scan the map window by window (memory read
// then test). The input takes no new item until the front has issued or
// dropped the current request. A mark lands in the map when the back writes
// it; a check waits until every mark ahead of it has landed. Front and back
// are joined by a one-entry request register and may overlap. After reset
// the maps are zeroed word by word while requests queue up. Configure only
// while idle.
module window_keep_read_filter_unit import wkrf_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [1:0]      cfg_idx_i,
  input  logic [CfgW-1:0] cfg_data_i,
  input  in_item_t        in_data_i,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output out_item_t       out_data_o,
  output logic            out_valid_o,
  input  logic            out_ready_i
);

  logic [CfgW-1:0]    win_size_q, win_step_q;
  logic [15:0]        trim_frac_q;
  req_t               req;
  logic               req_valid, req_ready;
  logic [MapIdxW:0]   lo_pos, lo_neg;
  logic [MapIdxW-1:0] hi_pos, hi_neg;
  logic               mark_busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_size_q  <= CfgW'(1000);
      win_step_q  <= CfgW'(100);
      trim_frac_q <= 16'd16384;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_WINDOW_SIZE:   win_size_q  <= cfg_data_i;
        CFG_WINDOW_STEP:   win_step_q  <= cfg_data_i;
        CFG_TRIM_FRACTION: trim_frac_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  wkrf_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .win_size_i  (win_size_q),
    .win_step_i  (win_step_q),
    .trim_frac_i (trim_frac_q),
    .lo_pos_i    (lo_pos),
    .hi_pos_i    (hi_pos),
    .lo_neg_i    (lo_neg),
    .hi_neg_i    (hi_neg),
    .mark_busy_i (mark_busy),
    .req_o       (req),
    .req_valid_o (req_valid),
    .req_ready_i (req_ready)
  );

  wkrf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req),
    .req_valid_i (req_valid),
    .req_ready_o (req_ready),
    .lo_pos_o    (lo_pos),
    .hi_pos_o    (hi_pos),
    .lo_neg_o    (lo_neg),
    .hi_neg_o    (hi_neg),
    .mark_busy_o (mark_busy),
    .out_o       (out_data_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i)
  );

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
  import wkrf_pkg::*;

  localparam int unsigned HoldLimit = 20000000;
  // longest scan of a whole map plus the front's work
  localparam int unsigned DrainWait = 2 * MapDepth + 200;

  typedef enum logic [1:0] {WANT_MODEL, WANT_NONE, WANT_KEEP} want_e;
  typedef struct {
    in_item_t it;
    want_e    want;
  } row_t;

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            cfg_we_i = 1'b0;
  logic [1:0]      cfg_idx_i = CFG_WINDOW_SIZE;
  logic [CfgW-1:0] cfg_data_i = '0;
  in_item_t        in_data_i = '0;
  logic            in_valid_i = 1'b0;
  logic            in_ready_o;
  out_item_t       out_data_o;
  logic            out_valid_o;
  logic            out_ready_i = 1'b0;

  window_keep_read_filter_unit dut (.*);

  always #5 clk_i = ~clk_i;

  // own copy of the block state
  bit          keep_map [2][MapDepth];
  int unsigned lo_mark [2];
  int unsigned hi_mark [2];
  longint      win_len, win_step, trim_q16;

  out_item_t   kept_q [$];
  row_t        rows [$];
  int unsigned errors = 0;
  longint      cycles = 0;
  bit          long_hold = 1'b0;

  function automatic void flag(string msg);
    errors++;
    if (errors <= 10) $display("MISMATCH: %s", msg);
  endfunction

  function automatic void add_row(in_item_t it, want_e want);
    row_t r;
    r.it   = it;
    r.want = want;
    rows.insert(rows.size(), r);
  endfunction

  function automatic longint floor_div(longint a, longint d);
    if (a >= 0) return a / d;
    return -((-a + d - 1) / d);
  endfunction

  // returns 1 when the request produces a kept read
  function automatic bit filter_request(in_item_t it);
    int     sd;
    longint s, e, len, mag, trim, first, last, lo, hi, step, i;
    bit     hit;
    sd = it.strand;
    if (it.operation == OP_MARK) begin
      keep_map[sd][it.window_index] = 1'b1;
      if (it.window_index < lo_mark[sd]) lo_mark[sd] = it.window_index;
      if (it.window_index > hi_mark[sd]) hi_mark[sd] = it.window_index;
      return 1'b0;
    end
    if (lo_mark[sd] >= MapDepth) return 1'b0;
    s    = it.read_start;
    e    = it.read_end;
    step = (win_step == 0) ? 1 : win_step;
    lo   = lo_mark[sd];
    hi   = hi_mark[sd];
    len  = e - s + 1;
    mag  = (len < 0) ? -len : len;
    trim = (mag * trim_q16) >>> 16;
    if (len < 0) trim = -trim;
    s += trim;
    e -= trim;
    first = 0;
    if (s > win_len) first = (s - win_len - 1 + step - 1) / step;
    last = hi;
    if (e < 1 + step * hi) last = floor_div(e, step);
    if (last < lo || first > hi) return 1'b0;
    i   = (first < lo) ? lo : first;
    // the first window is always tested, even past the clamped end
    hit = keep_map[sd][i];
    for (i = i + 1; !hit && i <= ((last > hi) ? hi : last); i++)
      hit = keep_map[sd][i];
    return hit;
  endfunction

  task automatic write_reg(cfg_idx_e idx, int unsigned val);
    @(negedge clk_i);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = val[CfgW-1:0];
    case (idx)
      CFG_WINDOW_SIZE:   win_len  = val & 32'h1FFFFF;
      CFG_WINDOW_STEP:   win_step = val & 32'h1FFFFF;
      CFG_TRIM_FRACTION: trim_q16 = val & 32'hFFFF;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic send(in_item_t it, want_e want);
    int unsigned gap;
    bit          hit;
    out_item_t   res;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_data_i  = it;
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    hit = filter_request(it);
    if (want != WANT_MODEL && hit != (want == WANT_KEEP))
      flag($sformatf("typed outcome %s, predicted hit %0d for id %0d",
                     want.name(), hit, it.read_id));
    if (hit) begin
      res.kept_id     = it.read_id;
      res.kept_strand = it.strand;
      kept_q.insert(kept_q.size(), res);
    end
    @(negedge clk_i);
  endtask

  task automatic settle();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (kept_q.size() != 0) @(negedge clk_i);
    repeat (DrainWait) @(negedge clk_i);
  endtask

  function automatic in_item_t mark_req(bit sd, int unsigned idx);
    in_item_t it;
    it              = '0;
    it.operation    = OP_MARK;
    it.strand       = sd;
    it.window_index = idx[15:0];
    it.read_start   = PosW'($urandom());
    it.read_end     = PosW'($urandom());
    it.read_id      = PosW'($urandom());
    return it;
  endfunction

  function automatic in_item_t check_req(bit sd, int unsigned s, int unsigned e,
                                         int unsigned id);
    in_item_t it;
    it              = '0;
    it.operation    = OP_CHECK;
    it.strand       = sd;
    it.window_index = 16'($urandom());
    it.read_start   = s[PosW-1:0];
    it.read_end     = e[PosW-1:0];
    it.read_id      = id[PosW-1:0];
    return it;
  endfunction

  // random mark or check request, most checks shaped to land inside the marked window range
  function automatic in_item_t random_req();
    longint      step, s, span;
    int unsigned pick;
    step = (win_step == 0) ? 1 : win_step;
    pick = $urandom_range(0, 99);
    if (pick < 30)
      return mark_req(1'($urandom_range(0, 1)), $urandom_range(0, 300));
    if (pick < 33)
      return check_req(1'($urandom_range(0, 1)), $urandom() >> 1, $urandom() >> 1,
                       $urandom() >> 1);
    s    = $urandom_range(0, 250) * step + $urandom_range(0, 99);
    span = $urandom_range(0, 3) * (win_len + 1) + $urandom_range(0, 300);
    if ($urandom_range(0, 9) == 0) span = -span / 4;
    if (s + span < 0) span = -s;
    if (s + span > 32'h7FFFFFFF) span = 32'h7FFFFFFF - s;
    return check_req(1'($urandom_range(0, 1)), 32'(s), 32'(s + span),
                     $urandom() >> 1);
  endfunction

  // receiver: random stalls, plus one long hold-off that backs up the block
  always @(negedge clk_i) begin
    static int unsigned stall = 0;
    if (long_hold) begin
      long_hold = 1'b0;
      stall = 600;
    end
    if (out_valid_o && out_ready_i)
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
    if (stall > 0) begin
      out_ready_i <= 1'b0;
      stall--;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    out_item_t want;
    cycles++;
    if (cycles > HoldLimit) begin
      $display("testbench failed");
      $finish;
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (kept_q.size() == 0) begin
        flag($sformatf("unexpected kept read id %0d strand %0d",
                       out_data_o.kept_id, out_data_o.kept_strand));
      end else begin
        want = kept_q.pop_front();
        if (out_data_o.kept_id != want.kept_id)
          flag($sformatf("kept_id exp %0d got %0d", want.kept_id,
                         out_data_o.kept_id));
        if (out_data_o.kept_strand != want.kept_strand)
          flag($sformatf("kept_strand exp %0d got %0d", want.kept_strand,
                         out_data_o.kept_strand));
      end
    end
  end

  initial begin
    int unsigned phase;
    for (int sd = 0; sd < 2; sd++) begin
      lo_mark[sd] = MapDepth;
      hi_mark[sd] = 0;
    end
    win_len  = 1000;
    win_step = 100;
    trim_q16 = 16384;

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed part, reset register values
    add_row(check_req(0, 600, 700, 1), WANT_NONE);
    add_row(mark_req(0, 5), WANT_NONE);
    add_row(mark_req(0, 5), WANT_NONE);
    add_row(mark_req(1, 0), WANT_NONE);
    add_row(check_req(0, 600, 700, 32'h7FFFFFFF), WANT_KEEP);
    add_row(check_req(0, 32'h7FFFFFFF, 32'h7FFFFFFF, 2), WANT_NONE);
    add_row(check_req(0, 0, 0, 3), WANT_NONE);
    add_row(check_req(0, 900, 100, 4), WANT_MODEL);
    add_row(check_req(1, 0, 50, 0), WANT_KEEP);
    add_row(check_req(1, 32'h7FFFFFFF, 0, 5), WANT_MODEL);
    add_row(check_req(1, 0, 32'h7FFFFFFF, 6), WANT_MODEL);
    add_row(mark_req(1, 9), WANT_NONE);
    add_row(check_req(1, 2000, 2100, 7), WANT_MODEL);
    add_row(check_req(1, 1050, 1060, 8), WANT_MODEL);
    add_row(mark_req(0, 200), WANT_NONE);
    add_row(check_req(0, 1500, 1600, 9), WANT_MODEL);
    add_row(check_req(0, 20500, 20600, 10), WANT_MODEL);
    add_row(mark_req(0, 65535), WANT_NONE);
    add_row(check_req(0, 20500, 20600, 11), WANT_MODEL);
    foreach (rows[k]) send(rows[k].it, rows[k].want);

    for (phase = 0; phase < 5; phase++) begin
      settle();
      case (phase)
        0: begin
          write_reg(CFG_WINDOW_SIZE, 1);
          write_reg(CFG_WINDOW_STEP, 1);
          write_reg(CFG_TRIM_FRACTION, 0);
        end
        1: begin
          write_reg(CFG_WINDOW_SIZE, 1048576);
          write_reg(CFG_WINDOW_STEP, 1048576);
          write_reg(CFG_TRIM_FRACTION, 32768);
        end
        2: begin
          // a step of zero acts as one
          write_reg(CFG_WINDOW_STEP, 0);
          write_reg(CFG_WINDOW_SIZE, $urandom_range(1, 500));
          write_reg(CFG_TRIM_FRACTION, $urandom_range(0, 65535));
        end
        3: begin
          write_reg(CFG_WINDOW_SIZE, $urandom_range(1, 1048576));
          write_reg(CFG_WINDOW_STEP, $urandom_range(1, 4000));
          write_reg(CFG_TRIM_FRACTION, $urandom_range(0, 32768));
        end
        default: begin
          write_reg(CFG_WINDOW_SIZE, 1000);
          write_reg(CFG_WINDOW_STEP, 100);
          write_reg(CFG_TRIM_FRACTION, 16384);
        end
      endcase
      for (int n = 0; n < 100; n++) begin
        if (phase == 1 && n == 10) long_hold = 1'b1;
        send(random_req(), WANT_MODEL);
      end
    end

    settle();
    if (errors == 0 && kept_q.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/wkrf_pkg.sv
src/wkrf_div.sv
src/wkrf_front.sv
src/wkrf_back.sv
src/window_keep_read_filter_unit.sv
tb/testbench.sv
